[hw/rtl/pcss_pkg.sv]
package pcss_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int CHAR_W   = 8;
    localparam int CMP_W    = ((LEN_W + 1 > POS_W) ? LEN_W + 1 : POS_W) + 1;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_EMIT   = 2'd3;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_EMIT   = 2'd1;
    localparam logic [1:0] KIND_BADPOS = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_RD_RD,
        ST_RD_OUT,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [CHAR_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

[hw/rtl/pcss_store.sv]
module pcss_store (
    input  logic                        clk,
    input  pcss_pkg::mem_req_t          req,
    output logic [pcss_pkg::CHAR_W-1:0] rdata
);
    import pcss_pkg::*;

    logic [CHAR_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

[hw/rtl/positional_char_sequence_store_top.sv]
// channel   signals                          accepted when
// -------   ------------------------------   -------------------------------
// command   start, action, position,         rising edge with start high and
//           char_value                       busy low
// result    strobe, kind, char_out, last     every edge ending a strobe cycle
//
// error results appear the cycle after the command, busy stays low
// busy is high while a command shifts, reads or emits bytes; the last beat of a read or emit
// arrives in the cycle after busy falls
// each moved byte passes through a read state and then a write state since the byte store read is registered
// reset clears the length, the state machine and the strobe; bytes are not cleared
// results are one-cycle beats the receiver cannot hold off
module positional_char_sequence_store_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [pcss_pkg::POS_W-1:0]  position,
    input  logic [pcss_pkg::CHAR_W-1:0] char_value,
    output logic                        strobe,
    output logic [1:0]                  kind,
    output logic [pcss_pkg::CHAR_W-1:0] char_out,
    output logic                        last
);
    import pcss_pkg::*;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic [CHAR_W-1:0] val_reg, val_next;
    logic              strobe_reg, strobe_next;
    logic [1:0]        kind_reg, kind_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    mem_req_t          mem_req;
    logic [CHAR_W-1:0] rdata;

    logic [CMP_W-1:0]  pos_ext, len_ext;
    logic [LEN_W-1:0]  idx_ext;

    pcss_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    assign pos_ext = CMP_W'(position);
    assign len_ext = CMP_W'(len_reg);
    assign idx_ext = LEN_W'(idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            len_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        val_reg  <= val_next;
        kind_reg <= kind_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        pidx_next     = pidx_reg;
        val_next      = val_reg;
        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg;
        mem_req.wdata = rdata;
        mem_req.raddr = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    val_next  = char_value;
                    pidx_next = IDX_W'(position - POS_W'(1));
                    kind_next = KIND_BADPOS;
                    char_next = '0;
                    last_next = 1'b1;
                    case (action)
                        ACT_INSERT:
                        begin
                            if (pos_ext == '0 || pos_ext > len_ext + CMP_W'(1))
                            begin
                                strobe_next = 1'b1;
                            end
                            else if (len_ext == CMP_W'(CAPACITY))
                            begin
                                strobe_next = 1'b1;
                                kind_next   = KIND_FULL;
                            end
                            else if (pos_ext <= len_ext)
                            begin
                                idx_next   = len_reg[IDX_W-1:0];
                                state_next = ST_INS_RD;
                            end
                            else
                            begin
                                state_next = ST_INS_PUT;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (pos_ext == '0 || pos_ext > len_ext)
                            begin
                                strobe_next = 1'b1;
                            end
                            else if (pos_ext < len_ext)
                            begin
                                idx_next   = IDX_W'(position - POS_W'(1));
                                state_next = ST_DEL_RD;
                            end
                            else
                            begin
                                len_next = len_reg - LEN_W'(1);
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_ext == '0 || pos_ext > len_ext)
                            begin
                                strobe_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_RD_RD;
                            end
                        end
                        default:
                        begin
                            if (len_reg == '0)
                            begin
                                strobe_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_EMIT_RD;
                            end
                        end
                    endcase
                end
            end
            // move the tail up one place, top end first
            ST_INS_RD:
            begin
                mem_req.raddr = idx_reg - IDX_W'(1);
                state_next    = ST_INS_WR;
            end
            ST_INS_WR:
            begin
                mem_req.we = 1'b1;
                idx_next   = idx_reg - IDX_W'(1);
                if (idx_reg - IDX_W'(1) == pidx_reg)
                begin
                    state_next = ST_INS_PUT;
                end
                else
                begin
                    state_next = ST_INS_RD;
                end
            end
            ST_INS_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pidx_reg;
                mem_req.wdata = val_reg;
                len_next      = len_reg + LEN_W'(1);
                state_next    = ST_IDLE;
            end
            // close the gap, low end first
            ST_DEL_RD:
            begin
                mem_req.raddr = idx_reg + IDX_W'(1);
                state_next    = ST_DEL_WR;
            end
            ST_DEL_WR:
            begin
                mem_req.we = 1'b1;
                idx_next   = idx_reg + IDX_W'(1);
                if (idx_ext + LEN_W'(2) == len_reg)
                begin
                    len_next   = len_reg - LEN_W'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DEL_RD;
                end
            end
            ST_RD_RD:
            begin
                mem_req.raddr = pidx_reg;
                state_next    = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_READ;
                char_next   = rdata;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_EMIT;
                char_next   = rdata;
                last_next   = (idx_ext + LEN_W'(1) == len_reg);
                idx_next    = idx_reg + IDX_W'(1);
                if (idx_ext + LEN_W'(1) == len_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign kind     = kind_reg;
    assign char_out = char_reg;
    assign last     = last_reg;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import pcss_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 2 * CAPACITY + 8;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] ch;
        logic              last_beat;
    } seq_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        action;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_value;
    logic              strobe;
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_out;
    logic              last;

    // shadow copy of the sequence
    logic [CHAR_W-1:0] seq_bytes [CAPACITY];
    int                seq_len;
    seq_result_t       pending_results [$];
    seq_result_t       want;

    int error_count;
    int burst_left;
    int idle_cycles;
    int beat_count;
    int peak_len;
    int full_hits;
    int badpos_hits;
    int act_count [4];

    positional_char_sequence_store_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .position   (position),
        .char_value (char_value),
        .strobe     (strobe),
        .kind       (kind),
        .char_out   (char_out),
        .last       (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void push_error(input logic [1:0] err_kind);
        seq_result_t r;
        r.kind      = err_kind;
        r.ch        = '0;
        r.last_beat = 1'b1;
        pending_results.push_back(r);
        if (err_kind == KIND_FULL)
            full_hits++;
        else
            badpos_hits++;
    endfunction

    // updates the shadow sequence and queues the beats this command causes
    function automatic void model_command(input logic [1:0] act, input logic [POS_W-1:0] pos,
                                          input logic [CHAR_W-1:0] val);
        int p;
        int i;
        seq_result_t r;
        p = pos;
        act_count[act]++;
        case (act)
            ACT_INSERT:
            begin
                if (p == 0 || p > seq_len + 1)
                    push_error(KIND_BADPOS);
                else if (seq_len >= CAPACITY)
                    push_error(KIND_FULL);
                else
                begin
                    for (i = seq_len; i > p - 1; i--)
                        seq_bytes[i] = seq_bytes[i-1];
                    seq_bytes[p-1] = val;
                    seq_len++;
                    if (seq_len > peak_len)
                        peak_len = seq_len;
                end
            end
            ACT_DELETE:
            begin
                if (p == 0 || p > seq_len)
                    push_error(KIND_BADPOS);
                else
                begin
                    for (i = p - 1; i + 1 < seq_len; i++)
                        seq_bytes[i] = seq_bytes[i+1];
                    seq_len--;
                end
            end
            ACT_READ:
            begin
                if (p == 0 || p > seq_len)
                    push_error(KIND_BADPOS);
                else
                begin
                    r.kind      = KIND_READ;
                    r.ch        = seq_bytes[p-1];
                    r.last_beat = 1'b1;
                    pending_results.push_back(r);
                end
            end
            default:
            begin
                if (seq_len == 0)
                    push_error(KIND_BADPOS);
                else
                begin
                    for (i = 0; i < seq_len; i++)
                    begin
                        r.kind      = KIND_EMIT;
                        r.ch        = seq_bytes[i];
                        r.last_beat = (i + 1 == seq_len);
                        pending_results.push_back(r);
                    end
                end
            end
        endcase
    endfunction

    // sender works in bursts; start stays high across back-to-back beats
    task automatic send_command(input logic [1:0] act, input logic [POS_W-1:0] pos,
                                input logic [CHAR_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start      <= 1'b1;
        action     <= act;
        position   <= pos;
        char_value <= val;
        do
            @(posedge clk);
        while (busy);
        model_command(act, pos, val);
    endtask

    task automatic test_empty_store;
        send_command(ACT_READ, 6'd1, 8'h3C);
        send_command(ACT_EMIT, 6'd0, 8'h00);
        send_command(ACT_DELETE, 6'd1, 8'h00);
        send_command(ACT_INSERT, 6'd0, 8'h11);
        send_command(ACT_INSERT, 6'd2, 8'h22);
        send_command(ACT_READ, 6'd0, 8'h00);
    endtask

    task automatic test_edit_positions;
        send_command(ACT_INSERT, 6'd1, 8'h00);
        send_command(ACT_INSERT, 6'd2, 8'hFF);
        send_command(ACT_INSERT, 6'd1, 8'hA5);   // new head
        send_command(ACT_INSERT, 6'd3, 8'h5A);   // middle
        send_command(ACT_READ, 6'd1, 8'h00);
        send_command(ACT_READ, 6'd4, 8'h00);
        send_command(ACT_READ, 6'd5, 8'h00);
        send_command(ACT_INSERT, 6'd6, 8'h77);
        send_command(ACT_INSERT, 6'd63, 8'h88);
        send_command(ACT_READ, 6'd63, 8'hFF);
        send_command(ACT_DELETE, 6'd0, 8'h00);
        send_command(ACT_DELETE, 6'd5, 8'h00);
        send_command(ACT_EMIT, 6'd42, 8'hC3);    // position ignored by emit
        send_command(ACT_DELETE, 6'd2, 8'h00);
        send_command(ACT_DELETE, 6'd3, 8'h00);
        send_command(ACT_DELETE, 6'd1, 8'h00);
        send_command(ACT_EMIT, 6'd63, 8'hFF);
    endtask

    task automatic test_fill_and_full;
        while (seq_len < CAPACITY)
            send_command(ACT_INSERT, POS_W'($urandom_range(1, seq_len + 1)), CHAR_W'($urandom));
        send_command(ACT_INSERT, POS_W'(CAPACITY + 1), 8'h99);
        send_command(ACT_INSERT, 6'd1, 8'h66);
        send_command(ACT_INSERT, POS_W'(CAPACITY + 2), 8'h55);  // bad position wins over full
        send_command(ACT_READ, POS_W'(CAPACITY), 8'h00);
        send_command(ACT_EMIT, 6'd0, 8'h00);
        send_command(ACT_DELETE, POS_W'(CAPACITY), 8'h00);
        send_command(ACT_READ, POS_W'(CAPACITY), 8'h00);
        while (seq_len > 6)
            send_command(ACT_DELETE, POS_W'($urandom_range(1, seq_len)), CHAR_W'($urandom));
    endtask

    // mostly legal commands with random content, some noise
    task automatic test_random_mix(input int n);
        int k;
        int sel;
        logic [1:0]       act;
        logic [POS_W-1:0] pos;
        for (k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                act = 2'($urandom_range(0, 3));
                pos = POS_W'($urandom_range(0, 63));
            end
            else if (sel < 50 || seq_len == 0)
            begin
                act = ACT_INSERT;
                pos = POS_W'($urandom_range(1, seq_len + 1));
            end
            else if (sel < 72)
            begin
                act = ACT_DELETE;
                pos = POS_W'($urandom_range(1, seq_len));
            end
            else if (sel < 94)
            begin
                act = ACT_READ;
                pos = POS_W'($urandom_range(1, seq_len));
            end
            else
            begin
                act = ACT_EMIT;
                pos = POS_W'($urandom_range(0, 63));
            end
            send_command(act, pos, CHAR_W'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            beat_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected beat kind=%0d char_out=%02h last=%0b",
                         $time, kind, char_out, last);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
                    error_count++;
                end
                if (char_out !== want.ch)
                begin
                    $display("%0t: char_out expected %02h actual %02h",
                             $time, want.ch, char_out);
                    error_count++;
                end
                if (last !== want.last_beat)
                begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last_beat, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d beats outstanding",
                     $time, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int waited;
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_INSERT;
        position    = '0;
        char_value  = '0;
        seq_len     = 0;
        error_count = 0;
        burst_left  = 0;
        idle_cycles = 0;
        beat_count  = 0;
        peak_len    = 0;
        full_hits   = 0;
        badpos_hits = 0;
        act_count   = '{0, 0, 0, 0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_edit_positions();
        test_fill_and_full();
        test_random_mix(64);

        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        // an insert or delete may still be shifting with nothing to report
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected beats never arrived", $time, pending_results.size());
            error_count++;
        end

        $display("covered %0d inserts, %0d deletes, %0d reads, %0d emits; %0d result beats",
                 act_count[ACT_INSERT], act_count[ACT_DELETE], act_count[ACT_READ],
                 act_count[ACT_EMIT], beat_count);
        $display("peak length %0d, %0d store-full and %0d bad-position errors",
                 peak_len, full_hits, badpos_hits);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[positional_char_sequence_store_top.f]
hw/rtl/pcss_pkg.sv
hw/rtl/pcss_store.sv
hw/rtl/positional_char_sequence_store_top.sv
tb/sv/testbench.sv
